>>> rtl/positional_insert_erase_list_unit_defines.svh
// Assertion macros used by the list unit top level.
`ifndef POSITIONAL_INSERT_ERASE_LIST_UNIT_DEFINES_SVH
`define POSITIONAL_INSERT_ERASE_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PLIE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PLIE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/plie_pkg.sv
// Shared types, codes and elaboration helpers for the list unit.
package plie_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int WIDTH_DEF = 32;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 2;
  localparam int FANIN_LOG = 3;  // read tree combines 8 nodes per level

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT     = 3'd4,
    OP_ERASE      = 3'd5,
    OP_GET        = 3'd6,
    OP_NONE       = 3'd7
  } plie_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } plie_status_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic ins;  // open a slot at 'at' and load the new word
    logic del;  // close the slot at 'at'
    logic rd;   // drive the word at 'at' onto the read tree
  } plie_ctrl_t;

  // Number of registered levels needed to reduce n leaves.
  function automatic int plie_levels(input int n);
    int lv;
    int span;
    lv   = 1;
    span = 1 << FANIN_LOG;
    while (span < n) begin
      span = span << FANIN_LOG;
      lv   = lv + 1;
    end
    return lv;
  endfunction

  // Nodes present at level l of a tree over n leaves (level 0 = leaves).
  function automatic int plie_nodes(input int n, input int l);
    return (n + (1 << (FANIN_LOG * l)) - 1) >> (FANIN_LOG * l);
  endfunction

endpackage

>>> rtl/plie_cell.sv
// One list slot: holds a word and trades it with its neighbors on insert and erase.
module plie_cell #(
  parameter int IDX   = 0,
  parameter int CW    = 7,
  parameter int WIDTH = 32
) (
  input  logic                clk,
  input  plie_pkg::plie_ctrl_t ctrl,
  input  logic [CW-1:0]       at,
  input  logic [CW-1:0]       used,
  input  logic [WIDTH-1:0]    lower,    // word of the slot below
  input  logic [WIDTH-1:0]    upper,    // word of the slot above
  input  logic [WIDTH-1:0]    din,
  output logic [WIDTH-1:0]    word,
  output logic [WIDTH-1:0]    rd_word
);
  import plie_pkg::*;

  localparam logic [CW-1:0] ME = CW'(IDX);

  logic [CW:0] me_plus1;

  assign me_plus1 = {1'b0, ME} + 1'b1;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (ME == at) begin
        word <= din;
      end else if (ME > at && ME <= used) begin
        word <= lower;
      end
    end else if (ctrl.del) begin
      if (ME >= at && me_plus1 < {1'b0, used}) begin
        word <= upper;
      end
    end
  end

  assign rd_word = (ctrl.rd && ME == at) ? word : '0;

endmodule

>>> rtl/plie_or_tree.sv
// Registered OR tree that gathers the selected word, with a stallable result pipeline.
module plie_or_tree #(
  parameter int N  = 64,
  parameter int W  = 32,
  parameter int MW = 9
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [W-1:0]  leaves [N],
  input  logic          in_valid,
  input  logic [MW-1:0] in_meta,
  output logic          in_ready,
  output logic          out_valid,
  output logic [W-1:0]  out_word,
  output logic [MW-1:0] out_meta,
  input  logic          out_ready
);
  import plie_pkg::*;

  localparam int LEVELS = plie_levels(N);
  localparam int FANIN  = 1 << FANIN_LOG;

  logic [W-1:0]  node [LEVELS+1][N];
  logic          vld  [LEVELS+1];
  logic [MW-1:0] meta [LEVELS+1];
  logic          en   [LEVELS+2];

  for (genvar j = 0; j < N; j++) begin : g_leaf
    assign node[0][j] = leaves[j];
  end
  assign vld[0]  = in_valid;
  assign meta[0] = in_meta;

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    en[LEVELS+1] = out_ready;
    for (int l = LEVELS; l >= 1; l--) begin
      en[l] = !vld[l] || en[l+1];
    end
    en[0] = en[1];
  end

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    localparam int PREV = plie_nodes(N, l - 1);
    localparam int CUR  = plie_nodes(N, l);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[l] <= 1'b0;
      end else if (en[l]) begin
        vld[l] <= vld[l-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en[l]) begin
        meta[l] <= meta[l-1];
      end
    end

    for (genvar j = 0; j < N; j++) begin : g_node
      if (j < CUR) begin : g_live
        logic [W-1:0] term [FANIN];
        logic [W-1:0] grp;

        for (genvar k = 0; k < FANIN; k++) begin : g_term
          if (j * FANIN + k < PREV) begin : g_on
            assign term[k] = node[l-1][j*FANIN+k];
          end else begin : g_off
            assign term[k] = '0;
          end
        end

        always_comb begin
          grp = '0;
          for (int k = 0; k < FANIN; k++) begin
            grp = grp | term[k];
          end
        end

        always_ff @(posedge clk) begin
          if (en[l]) begin
            node[l][j] <= grp;
          end
        end
      end else begin : g_dead
        assign node[l][j] = '0;
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[LEVELS];
  assign out_word  = node[LEVELS][0];
  assign out_meta  = meta[LEVELS];

endmodule

>>> rtl/positional_insert_erase_list_unit.sv
// Ordered list of DEPTH words with push/pop at both ends, insert, erase and get by position.
//
// Each list slot is a small cell; an insert shifts every slot from the
// position up by one, an erase shifts them down, both at once, so the
// list state is final at the edge that accepts the item and the next item
// may follow in the very next cycle. The word read by get, pop or erase is
// gathered through a registered OR tree of fan-in 8, so a result appears
// once its item has passed every tree level; throughput is one item per
// cycle while m_tready does not hold the output. The tree stages advance
// independently, so new items are taken while a result waits as long as
// a stage is free. Full, empty and bad-position requests leave the list
// untouched and report the status with data 0. Op code 7 is a no-op.
// No clearing pass: slot contents are only read below the word count.
`include "positional_insert_erase_list_unit_defines.svh"

module positional_insert_erase_list_unit #(
  parameter int DEPTH = plie_pkg::DEPTH_DEF,
  parameter int WIDTH = plie_pkg::WIDTH_DEF,
  parameter int CW    = $clog2(DEPTH + 1),
  parameter int IN_TW  = ((plie_pkg::OP_W + CW + WIDTH + 7) / 8) * 8,
  parameter int OUT_TW = ((WIDTH + CW + plie_pkg::STATUS_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,
  // input item
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_TW-1:0]  s_tdata,   // op[2:0], position[CW], data_in[WIDTH], zero pad
  // result item
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_TW-1:0] m_tdata    // data_out[WIDTH], count[CW], status[2], zero pad
);
  import plie_pkg::*;

  localparam int MW = CW + STATUS_W;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // request fields
  plie_op_t         op;
  logic [CW-1:0]    position;
  logic [WIDTH-1:0] data_in;

  // list state
  logic [CW-1:0]    used;
  logic [CW-1:0]    used_next;

  // decode
  logic             accept;
  logic             is_put;
  logic             is_take;
  logic [CW-1:0]    at;
  plie_status_t     status;
  plie_ctrl_t       ctrl;

  // cells and read tree
  logic [WIDTH-1:0] word    [DEPTH];
  logic [WIDTH-1:0] rd_word [DEPTH];
  logic [WIDTH-1:0] out_word;
  logic [MW-1:0]    out_meta;
  logic [CW-1:0]    m_count;
  plie_status_t     m_status;

  assign op       = plie_op_t'(s_tdata[OP_W-1:0]);
  assign position = s_tdata[OP_W +: CW];
  assign data_in  = s_tdata[OP_W+CW +: WIDTH];
  assign accept   = s_tvalid && s_tready;

  // Target slot and status, taken from the count before this item.
  always_comb begin
    is_put  = 1'b0;
    is_take = 1'b0;
    at      = '0;
    case (op)
      OP_PUSH_BACK: begin
        is_put = 1'b1;
        at     = used;
      end
      OP_PUSH_FRONT: begin
        is_put = 1'b1;
        at     = '0;
      end
      OP_INSERT: begin
        is_put = 1'b1;
        at     = position;
      end
      OP_POP_BACK: begin
        is_take = 1'b1;
        at      = used - 1'b1;
      end
      OP_POP_FRONT: begin
        is_take = 1'b1;
        at      = '0;
      end
      OP_ERASE, OP_GET: begin
        is_take = 1'b1;
        at      = position;
      end
      default: begin
        is_put  = 1'b0;
        is_take = 1'b0;
      end
    endcase
  end

  always_comb begin
    status = ST_OK;
    if (is_put) begin
      if (used >= FULL_CNT) begin
        status = ST_FULL;          // full is checked before position
      end else if (at > used) begin
        status = ST_RANGE;
      end
    end else if (is_take) begin
      if (used == '0) begin
        status = ST_EMPTY;         // empty is checked before position
      end else if (at >= used) begin
        status = ST_RANGE;
      end
    end
  end

  always_comb begin
    ctrl.ins  = accept && is_put && status == ST_OK;
    ctrl.del  = accept && is_take && status == ST_OK && op != OP_GET;
    ctrl.rd   = is_take && status == ST_OK;
    used_next = used;
    if (ctrl.ins) begin
      used_next = used + 1'b1;
    end else if (ctrl.del) begin
      used_next = used - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used_next;
    end
  end

  // The row of slots; the end cells see zero beyond the list.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] lower;
    logic [WIDTH-1:0] upper;

    if (i == 0) begin : g_lo_end
      assign lower = '0;
    end else begin : g_lo
      assign lower = word[i-1];
    end
    if (i == DEPTH - 1) begin : g_hi_end
      assign upper = '0;
    end else begin : g_hi
      assign upper = word[i+1];
    end

    plie_cell #(
      .IDX   (i),
      .CW    (CW),
      .WIDTH (WIDTH)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .at      (at),
      .used    (used),
      .lower   (lower),
      .upper   (upper),
      .din     (data_in),
      .word    (word[i]),
      .rd_word (rd_word[i])
    );
  end

  // Count and status ride with the read word through the tree stages.
  plie_or_tree #(
    .N  (DEPTH),
    .W  (WIDTH),
    .MW (MW)
  ) u_tree (
    .clk       (clk),
    .rst       (rst),
    .leaves    (rd_word),
    .in_valid  (accept),
    .in_meta   ({status, used_next}),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_word  (out_word),
    .out_meta  (out_meta),
    .out_ready (m_tready)
  );

  assign m_count  = out_meta[CW-1:0];
  assign m_status = plie_status_t'(out_meta[MW-1:CW]);
  assign m_tdata  = OUT_TW'({m_status, m_count, out_word});

  `PLIE_ASSERT_NOW(a_count_bound, 1'b1, used <= FULL_CNT, "word count above capacity")
  `PLIE_ASSERT_NEXT(a_ins_grows, ctrl.ins, used == $past(used) + 1'b1, "insert did not grow list")
  `PLIE_ASSERT_NOW(a_full_count, m_tvalid && m_status == ST_FULL, m_count == FULL_CNT,
                   "full status with list not full")
  `PLIE_ASSERT_NOW(a_empty_data, m_tvalid && m_status == ST_EMPTY,
                   m_count == '0 && out_word == '0, "empty status with words or data")

endmodule
